// ===== rtl/clsm_pkg.sv =====
// Shared constants and types for the store-merge line buffer.
// No dependencies; imported by all RTL and sim files.
package clsm_pkg;

    localparam int ADDR_W     = 64;
    localparam int DATA_W     = 64;
    localparam int SIZE_W     = 4;
    localparam int LINE_BYTES = 64;
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int HI_W       = ADDR_W - OFF_W;
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROWS       = LINE_BYTES / LANES;
    localparam int ROW_W      = OFF_W - LANE_W;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(LANES);
    localparam logic [OFF_W:0]    LINE_END = (OFF_W + 1)'(LINE_BYTES);

    typedef enum logic [1:0] {
        KIND_STORE = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Decoded access handed to the line storage
    typedef struct packed {
        logic              store_en;
        logic              mark_en;
        logic              rd_en;
        logic              mark;
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic [LANES-1:0]  in_line;
        logic [DATA_W-1:0] data;
    } line_req_t;

endpackage

// ===== rtl/clsm_line.sv =====
// Line storage: eight byte banks with per-byte valid bits, byte merge and read rotate.
// Depends on clsm_pkg.
module clsm_line
    import clsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  line_req_t         req,
    output logic [DATA_W-1:0] rd_data
);

    // byte with line offset o sits in bank o % LANES, row o / LANES
    logic [7:0] line_data_reg  [LANES][ROWS];
    logic       line_valid_reg [LANES][ROWS];

    logic [LANE_W-1:0] lane   [LANES];
    logic [ROW_W-1:0]  row    [LANES];
    logic              bank_we[LANES];
    logic [7:0]        wr_byte[LANES];
    logic [7:0]        rd_bank[LANES];

    // each bank sees at most one byte of an access: map bank -> access lane
    always_comb
    begin
        logic [OFF_W-1:0] pos;
        for (int b = 0; b < LANES; b++)
        begin
            lane[b]    = LANE_W'(b) - req.off[LANE_W-1:0];
            pos        = req.off + OFF_W'(lane[b]);
            row[b]     = pos[OFF_W-1:LANE_W];
            bank_we[b] = req.mark_en && req.in_line[lane[b]];
            wr_byte[b] = req.data[8*lane[b] +: 8];
            rd_bank[b] = line_data_reg[b][row[b]];
        end
    end

    always_comb
    begin
        logic [LANE_W-1:0] bsel;
        for (int i = 0; i < LANES; i++)
        begin
            bsel = req.off[LANE_W-1:0] + LANE_W'(i);
            if (req.rd_en && (SIZE_W'(i) < req.size))
                rd_data[8*i +: 8] = rd_bank[bsel];
            else
                rd_data[8*i +: 8] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < LANES; b++)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    line_data_reg[b][r]  <= 8'h00;
                    line_valid_reg[b][r] <= 1'b0;
                end
            end
        end
        else
        begin
            for (int b = 0; b < LANES; b++)
            begin
                if (bank_we[b])
                begin
                    if (req.store_en)
                        line_data_reg[b][row[b]] <= wr_byte[b];
                    line_valid_reg[b][row[b]] <= req.mark;
                end
            end
        end
    end

endmodule

// ===== rtl/cache_line_store_merge.sv =====
// Top level of the store-merge line buffer: input register, address decode, result register.
// Depends on clsm_pkg and clsm_line.
//
//  channel  | handshake     | payload
//  ---------+---------------+-----------------------------------------------------------
//  command  | start / busy  | kind, access_addr, access_size, store_data, line_addr,
//           |               | mark_value
//  result   | done (strobe) | read_data, access_error
//
// A transaction is taken on any edge with start high; busy is never raised.
// The accepting edge loads the input register; the next edge takes the line update and
// loads the result register, so done is high in the cycle after that. Rate one per cycle.
// Line data and valid bits are cleared by rst_n; no clearing pass is needed.
// done is a one-cycle strobe and cannot be held off.
module cache_line_store_merge
    import clsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] access_addr,
    input  logic [SIZE_W-1:0] access_size,
    input  logic [DATA_W-1:0] store_data,
    input  logic [ADDR_W-1:0] line_addr,
    input  logic              mark_value,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              access_error
);

    logic              in_valid_reg;
    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [DATA_W-1:0] data_reg;
    logic [HI_W-1:0]   line_hi_reg;
    logic              mark_reg;

    logic              done_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              access_error_reg;

    logic [SIZE_W-1:0] size_c;
    logic [OFF_W-1:0]  lo;
    logic [HI_W-1:0]   hi;
    logic              eq0;
    logic              eq1;
    logic [LANES-1:0]  in_line;
    logic              rd_err;
    logic              err_next;
    line_req_t         req;
    logic [DATA_W-1:0] rd_data;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg    <= kind;
            addr_reg    <= access_addr;
            size_reg    <= access_size;
            data_reg    <= store_data;
            line_hi_reg <= line_addr[ADDR_W-1:OFF_W];
            mark_reg    <= mark_value;
        end
    end

    // A byte at addr + i lies in the line when its upper bits match the base,
    // allowing for a carry out of the offset (store starting in the line before).
    always_comb
    begin
        logic [OFF_W:0] sum;
        size_c = (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
        lo     = addr_reg[OFF_W-1:0];
        hi     = addr_reg[ADDR_W-1:OFF_W];
        eq0    = (hi == line_hi_reg);
        eq1    = ((hi + HI_W'(1)) == line_hi_reg);
        for (int i = 0; i < LANES; i++)
        begin
            sum        = {1'b0, lo} + (OFF_W + 1)'(i);
            in_line[i] = (SIZE_W'(i) < size_c) && (sum[OFF_W] ? eq1 : eq0);
        end
        rd_err = (({1'b0, lo} + (OFF_W + 1)'(size_c)) > LINE_END);
    end

    always_comb
    begin
        req          = '0;
        req.mark     = mark_reg;
        req.off      = lo;
        req.size     = size_c;
        req.in_line  = in_line;
        req.data     = data_reg;
        err_next     = 1'b0;
        case (kind_reg)
            KIND_STORE:
            begin
                req.store_en = in_valid_reg;
                req.mark_en  = in_valid_reg;
                err_next     = (size_c != '0) && (in_line == '0);
            end
            KIND_MARK:
            begin
                req.mark_en = in_valid_reg;
                err_next    = (size_c != '0) && (in_line == '0);
            end
            KIND_READ:
            begin
                req.rd_en = in_valid_reg && !rd_err;
                err_next  = rd_err;
            end
            default:
            begin
                err_next = 1'b0;
            end
        endcase
    end

    clsm_line u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            read_data_reg    <= rd_data;
            access_error_reg <= err_next;
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign access_error = access_error_reg;

    // every transaction in the input register yields exactly one result next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done_reg)
        else $error("transaction lost between input and result register");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> !done_reg)
        else $error("result strobe without a transaction");

    a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && kind_reg != KIND_READ) |=> (read_data_reg == '0))
        else $error("non-read transaction returned data");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && access_error_reg) |-> (read_data_reg == '0))
        else $error("errored transaction returned data");

endmodule

// ===== sim/cache_line_store_merge_chk.sv =====
`timescale 1ns / 1ps
// Checker for the store-merge line buffer: watches the command and result channels,
// predicts each result from its own copy of the line, compares field by field.
// Depends on clsm_pkg.
module cache_line_store_merge_chk
    import clsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] access_addr,
    input  logic [SIZE_W-1:0] access_size,
    input  logic [DATA_W-1:0] store_data,
    input  logic [ADDR_W-1:0] line_addr,
    input  logic              mark_value,
    input  logic              done,
    input  logic [DATA_W-1:0] read_data,
    input  logic              access_error,
    output int                fail_count,
    output int                pending_results
);

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
    } access_result_t;

    logic [7:0]     line_data [LINE_BYTES];
    logic           line_valid [LINE_BYTES];
    access_result_t expected_results [$];
    access_result_t oldest;
    int             fails;

    // Applies one transaction to the line copy and returns what the block should answer
    function automatic access_result_t merge_line_access(
        input logic [1:0]        k,
        input logic [ADDR_W-1:0] addr,
        input logic [SIZE_W-1:0] size_in,
        input logic [DATA_W-1:0] data,
        input logic [ADDR_W-1:0] laddr,
        input logic              mark
    );
        access_result_t    res;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] byte_dist;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
        logic              hit;

        base = laddr & ~(ADDR_W'(LINE_BYTES) - ADDR_W'(1));
        size = (size_in > MAX_SIZE) ? MAX_SIZE : size_in;
        res.read_data = '0;
        res.access_error = 1'b0;
        hit = 1'b0;
        case (k)
            KIND_STORE, KIND_MARK:
            begin
                if (size != '0)
                begin
                    // distances wrap modulo 2^64, so a store from the line before hits the head
                    for (int i = 0; i < LANES; i++)
                        if (i < size && (addr + ADDR_W'(i) - base) < ADDR_W'(LINE_BYTES))
                            hit = 1'b1;
                    if (!hit)
                        res.access_error = 1'b1;
                    else
                    begin
                        for (int i = 0; i < LANES; i++)
                        begin
                            byte_dist = addr + ADDR_W'(i) - base;
                            if (i < size && byte_dist < ADDR_W'(LINE_BYTES))
                            begin
                                if (k == KIND_STORE)
                                    line_data[byte_dist[OFF_W-1:0]] = data[8*i +: 8];
                                line_valid[byte_dist[OFF_W-1:0]] = mark;
                            end
                        end
                    end
                end
            end
            KIND_READ:
            begin
                off = addr[OFF_W-1:0];
                if (int'(off) + int'(size) > LINE_BYTES)
                    res.access_error = 1'b1;
                else
                    for (int i = 0; i < LANES; i++)
                        if (i < size)
                            res.read_data[8*i +: 8] = line_data[int'(off) + i];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LINE_BYTES; j++)
            begin
                line_data[j] = '0;
                line_valid[j] = 1'b0;
            end
            expected_results.delete();
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            fails = fail_count;
            // results first: a result never belongs to a transaction taken at the same edge
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, read_data %h access_error %b",
                             $time, read_data, access_error);
                    fails++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (oldest.read_data !== read_data)
                    begin
                        $display("%0t: read_data expected %h, actual %h",
                                 $time, oldest.read_data, read_data);
                        fails++;
                    end
                    if (oldest.access_error !== access_error)
                    begin
                        $display("%0t: access_error expected %b, actual %b",
                                 $time, oldest.access_error, access_error);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(merge_line_access(kind, access_addr, access_size,
                                                             store_data, line_addr,
                                                             mark_value));
            fail_count <= fails;
            pending_results <= expected_results.size();
        end
    end

endmodule

// ===== sim/cache_line_store_merge_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the store-merge line buffer: clock, reset, directed and random
// transactions, stall watchdog and verdict. Depends on clsm_pkg,
// cache_line_store_merge and cache_line_store_merge_chk.
module cache_line_store_merge_tb;
    import clsm_pkg::*;

    localparam logic [1:0]        KIND_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] LAST_LINE   = 64'hFFFF_FFFF_FFFF_FFC0;
    localparam logic [ADDR_W-1:0] HELD_BASE   = 64'h0123_4567_89AB_CDC0;
    localparam logic [ADDR_W-1:0] HELD_LADDR  = 64'h0123_4567_89AB_CDEF;
    localparam int                STALL_LIMIT = 2000;
    localparam int                PHASES      = 11;
    localparam int                PHASE_ITEMS = 48;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] access_addr;
    logic [SIZE_W-1:0] access_size;
    logic [DATA_W-1:0] store_data;
    logic [ADDR_W-1:0] line_addr;
    logic              mark_value;
    logic              done;
    logic [DATA_W-1:0] read_data;
    logic              access_error;
    int                fail_count;
    int                pending_results;
    int                idle_cycles;

    cache_line_store_merge i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .access_addr  (access_addr),
        .access_size  (access_size),
        .store_data   (store_data),
        .line_addr    (line_addr),
        .mark_value   (mark_value),
        .done         (done),
        .read_data    (read_data),
        .access_error (access_error)
    );

    cache_line_store_merge_chk i_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .access_addr     (access_addr),
        .access_size     (access_size),
        .store_data      (store_data),
        .line_addr       (line_addr),
        .mark_value      (mark_value),
        .done            (done),
        .read_data       (read_data),
        .access_error    (access_error),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ends the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL cache_line_store_merge");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Drives one transaction and returns at the edge that takes it
    task automatic issue_access(
        input logic [1:0]        k,
        input logic [ADDR_W-1:0] addr,
        input logic [SIZE_W-1:0] size,
        input logic [DATA_W-1:0] data,
        input logic [ADDR_W-1:0] laddr,
        input logic              mark
    );
        kind <= k;
        access_addr <= addr;
        access_size <= size;
        store_data <= data;
        line_addr <= laddr;
        mark_value <= mark;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mostly well-formed accesses near the current line; some stray addresses, sizes, kinds
    task automatic issue_random_access(input logic [ADDR_W-1:0] line_base);
        int                pick;
        logic [1:0]        k;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] laddr;

        pick = $urandom_range(0, 99);
        if (pick < 40)
            k = KIND_STORE;
        else if (pick < 55)
            k = KIND_MARK;
        else if (pick < 96)
            k = KIND_READ;
        else
            k = KIND_UNUSED;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            size = '0;
        else if (pick == 1)
            size = SIZE_W'($urandom_range(9, 15));
        else
            size = SIZE_W'($urandom_range(1, 8));
        if ($urandom_range(0, 4) == 0)
            addr = {$urandom, $urandom};
        else
            addr = line_base + ADDR_W'($urandom_range(0, LINE_BYTES + 15)) - ADDR_W'(8);
        if ($urandom_range(0, 9) == 0)
            laddr = {$urandom, $urandom};
        else
            laddr = line_base | ADDR_W'($urandom_range(0, LINE_BYTES - 1));
        issue_access(k, addr, size, {$urandom, $urandom}, laddr, 1'($urandom_range(0, 1)));
    endtask

    task automatic idle_gap(input bit quiet);
        int pick;
        int gap;

        gap = 0;
        if (!quiet)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 95)
                gap = $urandom_range(10, 40);
            else if (pick >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] line_base;
        int                pick;

        rst_n <= 1'b0;
        start <= 1'b0;
        kind <= KIND_STORE;
        access_addr <= '0;
        access_size <= '0;
        store_data <= '0;
        line_addr <= '0;
        mark_value <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty line, clipping at both ends, misses, odd sizes, unused kind
        issue_access(KIND_READ, HELD_BASE, 4'd8, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_STORE, HELD_BASE, 4'd8, 64'h0706_0504_0302_0100, HELD_LADDR, 1'b1);
        issue_access(KIND_STORE, HELD_BASE + 56, 4'd8, '1, HELD_LADDR, 1'b1);
        issue_access(KIND_STORE, HELD_BASE + 60, 4'd8, 64'hA5A5_5A5A_C3C3_3C3C, HELD_LADDR, 1'b0);
        issue_access(KIND_STORE, HELD_BASE - 3, 4'd8, 64'h8877_6655_4433_2211, HELD_LADDR, 1'b1);
        issue_access(KIND_MARK, HELD_BASE + 16, 4'd4, 64'hDEAD_BEEF_DEAD_BEEF, HELD_LADDR, 1'b0);
        issue_access(KIND_MARK, HELD_BASE + 20, 4'd3, '0, HELD_LADDR, 1'b1);
        issue_access(KIND_STORE, HELD_BASE + 64, 4'd8, '1, HELD_LADDR, 1'b1);
        issue_access(KIND_MARK, HELD_BASE - 8, 4'd8, '0, HELD_LADDR, 1'b1);
        issue_access(KIND_STORE, HELD_BASE + 24, 4'd0, '1, HELD_LADDR, 1'b1);
        issue_access(KIND_STORE, HELD_BASE + 8, 4'd15, 64'hFEDC_BA98_7654_3210, HELD_LADDR, 1'b1);
        issue_access(KIND_READ, HELD_BASE, 4'd8, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 8, 4'd8, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 56, 4'd8, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 60, 4'd4, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 61, 4'd4, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 63, 4'd1, '0, '1, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 32, 4'd0, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 56, 4'd12, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_READ, HELD_BASE + 57, 4'd9, '0, HELD_LADDR, 1'b0);
        issue_access(KIND_UNUSED, HELD_BASE, 4'd8, '1, HELD_LADDR, 1'b1);
        // address wrap: top-of-memory stores into line zero and into the last line
        issue_access(KIND_STORE, '1 - 2, 4'd8, 64'h1122_3344_5566_7788, '0, 1'b1);
        issue_access(KIND_READ, '0, 4'd8, '0, '0, 1'b0);
        issue_access(KIND_STORE, '1 - 1, 4'd8, 64'h99AA_BBCC_DDEE_FF00, LAST_LINE, 1'b1);
        issue_access(KIND_READ, LAST_LINE + 56, 4'd8, '0, LAST_LINE, 1'b0);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                line_base = '0;
            else if (pick < 4)
                line_base = LAST_LINE;
            else
                line_base = {$urandom, $urandom} & ~(ADDR_W'(LINE_BYTES) - ADDR_W'(1));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                issue_random_access(line_base);
                idle_gap(phase % 3 == 0);
            end
            if (phase == 3 || phase == 7)
                drain_results();
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS cache_line_store_merge");
        else
            $display("FAIL cache_line_store_merge");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/clsm_pkg.sv
rtl/clsm_line.sv
rtl/cache_line_store_merge.sv
sim/cache_line_store_merge_chk.sv
sim/cache_line_store_merge_tb.sv
